### sv/opi_pkg.sv
`timescale 1ns / 1ps

package opi_pkg;

	// Default number of CORDIC iterations.
	localparam int CORDIC_STEPS_DEF = 16;

	// round(2^24 / (2*pi)): radians in Q.32 to binary angle.
	localparam logic [21:0] TURN_INV = 22'd2670177;

	// CORDIC starting gain, 0.60725 in Q1.30.
	localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

	// Quarter and half turn as binary angles, widened for the angle register.
	localparam logic signed [33:0] QUARTER = 34'sd1073741824;
	localparam logic signed [33:0] HALF = 34'sd2147483648;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MWD,
		ST_SP,
		ST_MVD,
		ST_SDIST,
		ST_MPLO,
		ST_SPLO,
		ST_MPHI,
		ST_SPHI,
		ST_CINIT,
		ST_CITER,
		ST_CDONE,
		ST_MDX,
		ST_SDX,
		ST_MDY,
		ST_SDY,
		ST_MR1,
		ST_SR1,
		ST_MR2,
		ST_SR2,
		ST_RND,
		ST_SAT,
		ST_OUT
	} state_t;

	// Which angle the shared CORDIC is working on.
	typedef enum logic [1:0] {
		PASS_DTH,
		PASS_HEAD,
		PASS_HALF
	} pass_t;

	// Arctangent table, binary angle with a full turn of 2^32.
	function automatic logic [29:0] atan_lut(input logic [4:0] idx);
		logic [29:0] r;
		case (idx)
			5'd0: r = 30'd536870912;
			5'd1: r = 30'd316933406;
			5'd2: r = 30'd167458907;
			5'd3: r = 30'd85004756;
			5'd4: r = 30'd42667331;
			5'd5: r = 30'd21354465;
			5'd6: r = 30'd10679838;
			5'd7: r = 30'd5340245;
			5'd8: r = 30'd2670163;
			5'd9: r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			5'd24: r = 30'd41;
			5'd25: r = 30'd20;
			5'd26: r = 30'd10;
			5'd27: r = 30'd5;
			5'd28: r = 30'd3;
			5'd29: r = 30'd1;
			5'd30: r = 30'd1;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

endpackage

### sv/odometry_pose_integrator.sv
`timescale 1ns / 1ps

// Dead-reckoning pose integrator. Each transaction on the input channel
// brings a forward speed, a yaw rate and an elapsed time; the block turns the
// local step by the stored heading, adds it to the saturating Q16.16 position,
// advances the wrapping binary-angle heading and returns one result
// transaction with the pose and the yaw quaternion. All work runs on one
// shared 34 by 34 multiplier and one shared CORDIC rotator under a sequencer,
// so the block takes one item at a time: an item passes through the three
// CORDIC passes and the ten multiplier steps, and its result may then wait
// for the previous one to be taken. in_stall is high from acceptance until
// the block has handed the result to its output register.
module odometry_pose_integrator import opi_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] lin_vel,
	input  logic signed [23:0] ang_vel,
	input  logic [15:0]        elapsed,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading,
	output logic signed [15:0] quat_z,
	output logic signed [15:0] quat_w
);

	localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

	state_t state_q, state_d;
	pass_t  pass_q;
	logic   rot_q;

	logic signed [23:0] v_q, w_q;
	logic [15:0]        dt_q;
	logic [39:0]        p_q;
	logic [55:0]        tacc_q;
	logic [31:0]        dang_q;
	logic signed [31:0] dist_q;
	logic signed [32:0] cd_q, sd_q, ch_q, sh_q;
	logic signed [33:0] dx_q, dy_q;
	logic signed [67:0] sum_q;
	logic signed [29:0] inc_q;
	logic signed [31:0] acc_x_q, acc_y_q;
	logic [31:0]        acc_h_q;

	logic signed [32:0] cx_q, cy_q;
	logic signed [33:0] cz_q;
	logic               flip_q;
	logic [IW-1:0]      iter_q;

	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod_q;

	logic               out_valid_q;
	logic signed [31:0] pos_x_q, pos_y_q, heading_q;
	logic signed [15:0] quat_z_q, quat_w_q;

	logic               accept;
	logic               out_free;
	logic               last_iter;

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign last_iter = (iter_q == IW'(CORDIC_STEPS - 1));
	assign in_stall  = (state_q != ST_IDLE);

	// Rounds a Q1.30 value to Q1.15 and clamps it.
	function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
		logic signed [33:0] t;
		logic signed [18:0] r;
		t = 34'(v) + 34'sd16384;
		r = t[33:15];
		if (r > 19'sd32767) begin
			return 16'sh7fff;
		end else if (r < -19'sd32768) begin
			return 16'sh8000;
		end
		return r[15:0];
	endfunction

	// Adds a Q16.16 increment with saturation to the 32-bit range.
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [29:0] b);
		logic signed [32:0] r;
		r = 33'(a) + 33'(b);
		if (r > 33'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (r < -33'sd2147483648) begin
			return 32'sh80000000;
		end
		return r[31:0];
	endfunction

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MWD: begin
				mul_a = 34'(w_q);
				mul_b = 34'(dt_q);
			end
			ST_MVD: begin
				mul_a = 34'(v_q);
				mul_b = 34'(dt_q);
			end
			ST_MPLO: begin
				mul_a = 34'(p_q[19:0]);
				mul_b = 34'(TURN_INV);
			end
			ST_MPHI: begin
				mul_a = 34'(signed'(p_q[39:20]));
				mul_b = 34'(TURN_INV);
			end
			ST_MDX: begin
				mul_a = 34'(dist_q);
				mul_b = 34'(cd_q);
			end
			ST_MDY: begin
				mul_a = 34'(dist_q);
				mul_b = 34'(sd_q);
			end
			ST_MR1: begin
				mul_a = dx_q;
				mul_b = rot_q ? 34'(sh_q) : 34'(ch_q);
			end
			ST_MR2: begin
				mul_a = dy_q;
				mul_b = rot_q ? 34'(ch_q) : 34'(sh_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Product register of the shared multiplier.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_MWD;
			ST_MWD:   state_d = ST_SP;
			ST_SP:    state_d = ST_MVD;
			ST_MVD:   state_d = ST_SDIST;
			ST_SDIST: state_d = ST_MPLO;
			ST_MPLO:  state_d = ST_SPLO;
			ST_SPLO:  state_d = ST_MPHI;
			ST_MPHI:  state_d = ST_SPHI;
			ST_SPHI:  state_d = ST_CINIT;
			ST_CINIT: state_d = ST_CITER;
			ST_CITER: if (last_iter) state_d = ST_CDONE;
			ST_CDONE: begin
				case (pass_q)
					PASS_DTH:  state_d = ST_MDX;
					PASS_HEAD: state_d = ST_MR1;
					default:   state_d = ST_OUT;
				endcase
			end
			ST_MDX:   state_d = ST_SDX;
			ST_SDX:   state_d = ST_MDY;
			ST_MDY:   state_d = ST_SDY;
			ST_SDY:   state_d = ST_CINIT;
			ST_MR1:   state_d = ST_SR1;
			ST_SR1:   state_d = ST_MR2;
			ST_MR2:   state_d = ST_SR2;
			ST_SR2:   state_d = ST_RND;
			ST_RND:   state_d = ST_SAT;
			ST_SAT:   state_d = rot_q ? ST_CINIT : ST_MR1;
			ST_OUT:   if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control registers: CORDIC pass, rotation half and accumulated pose.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_q  <= PASS_DTH;
			rot_q   <= 1'b0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_h_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: pass_q <= PASS_DTH;
				ST_SDY: begin
					pass_q <= PASS_HEAD;
					rot_q  <= 1'b0;
				end
				ST_SAT: begin
					if (rot_q) begin
						acc_y_q <= sat_add(acc_y_q, inc_q);
						acc_h_q <= acc_h_q + dang_q;
						pass_q  <= PASS_HALF;
					end else begin
						acc_x_q <= sat_add(acc_x_q, inc_q);
						rot_q   <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Datapath registers written step by step by the sequencer.
	always_ff @(posedge clk) begin
		logic signed [40:0] t41;
		logic signed [67:0] t68;
		logic [55:0]        s56;
		logic [31:0]        ang;
		logic signed [33:0] za;
		logic [29:0]        at;
		t41 = 41'(signed'(prod_q[39:0])) + 41'sd128;
		t68 = prod_q + (68'sd1 <<< 29);
		s56 = tacc_q + {prod_q[35:0], 20'b0} + 56'd8388608;
		at  = atan_lut(5'(iter_q));
		case (pass_q)
			PASS_DTH:  ang = dang_q;
			PASS_HEAD: ang = acc_h_q;
			default:   ang = {acc_h_q[31], acc_h_q[31:1]};
		endcase
		za = 34'(signed'(ang));
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					v_q  <= lin_vel;
					w_q  <= ang_vel;
					dt_q <= elapsed;
				end
			end
			ST_SP:    p_q <= prod_q[39:0];
			ST_SDIST: dist_q <= t41[39:8];
			ST_SPLO:  tacc_q <= prod_q[55:0];
			ST_SPHI:  dang_q <= s56[55:24];
			ST_CINIT: begin
				// Fold angles beyond a quarter turn by a half turn.
				cx_q   <= CORDIC_GAIN;
				cy_q   <= '0;
				iter_q <= '0;
				if (za > QUARTER) begin
					cz_q   <= za - HALF;
					flip_q <= 1'b1;
				end else if (za < -QUARTER) begin
					cz_q   <= za + HALF;
					flip_q <= 1'b1;
				end else begin
					cz_q   <= za;
					flip_q <= 1'b0;
				end
			end
			ST_CITER: begin
				// One micro-rotation toward a zero residual angle.
				if (!cz_q[33]) begin
					cx_q <= cx_q - (cy_q >>> iter_q);
					cy_q <= cy_q + (cx_q >>> iter_q);
					cz_q <= cz_q - 34'(at);
				end else begin
					cx_q <= cx_q + (cy_q >>> iter_q);
					cy_q <= cy_q - (cx_q >>> iter_q);
					cz_q <= cz_q + 34'(at);
				end
				iter_q <= iter_q + 1'b1;
			end
			ST_CDONE: begin
				if (pass_q == PASS_DTH) begin
					cd_q <= flip_q ? -cx_q : cx_q;
					sd_q <= flip_q ? -cy_q : cy_q;
				end else if (pass_q == PASS_HEAD) begin
					ch_q <= flip_q ? -cx_q : cx_q;
					sh_q <= flip_q ? -cy_q : cy_q;
				end
			end
			ST_SDX: dx_q <= t68[63:30];
			ST_SDY: dy_q <= t68[63:30];
			ST_SR1: sum_q <= prod_q;
			ST_SR2: sum_q <= rot_q ? (sum_q + prod_q) : (sum_q - prod_q);
			ST_RND: inc_q <= 30'(68'(sum_q + (68'sd1 <<< 37)) >>> 38);
			default: begin
			end
		endcase
	end

	// Output register: holds one result until its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			pos_x_q   <= acc_x_q;
			pos_y_q   <= acc_y_q;
			heading_q <= acc_h_q;
			quat_z_q  <= to_q15(flip_q ? -cy_q : cy_q);
			quat_w_q  <= to_q15(flip_q ? -cx_q : cx_q);
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x     = pos_x_q;
	assign pos_y     = pos_y_q;
	assign heading   = heading_q;
	assign quat_z    = quat_z_q;
	assign quat_w    = quat_w_q;

endmodule

### sim/tb_odometry_pose_integrator.sv
`timescale 1ns / 1ps

// Scoreboard: predicts the pose after each accepted transaction and holds the
// predicted results until the block returns them.
class pose_scoreboard;
	logic [31:0] px, py, ph;
	logic [31:0] q_x[$], q_y[$], q_h[$];
	logic [15:0] q_qz[$], q_qw[$];
	int errors;

	function new();
		px = 0;
		py = 0;
		ph = 0;
		errors = 0;
	endfunction

	static function longint atan_of(int i);
		longint t[32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772,
			166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326,
			163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
		return t[i];
	endfunction

	// Rounding right shift, floor(v / 2^n + 1/2).
	static function longint round_shift(longint v, int n);
		return (v + (64'sd1 <<< (n - 1))) >>> n;
	endfunction

	// Rotation-mode CORDIC with half-turn folding.
	static function void sincos(logic [31:0] ang, output longint c, output longint s);
		longint z, x, y, nx, ny;
		bit flip;
		z = longint'($signed(ang));
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 64'sd1073741824) begin
			z -= 64'sd2147483648;
			flip = 1;
		end else if (z < -64'sd1073741824) begin
			z += 64'sd2147483648;
			flip = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= atan_of(i);
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += atan_of(i);
			end
			x = nx;
			y = ny;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	static function logic [31:0] sat_sum(logic [31:0] a, longint inc);
		longint r;
		r = longint'($signed(a)) + inc;
		if (r > 64'sd2147483647) r = 64'sd2147483647;
		if (r < -64'sd2147483648) r = -64'sd2147483648;
		return r[31:0];
	endfunction

	static function logic [15:0] to_q15(longint v);
		longint r;
		r = round_shift(v, 15);
		if (r > 32767) r = 32767;
		if (r < -32768) r = -32768;
		return r[15:0];
	endfunction

	// Note an accepted input transaction and queue its predicted result.
	function void note_motion(logic signed [23:0] v, logic signed [23:0] w,
			logic [15:0] dt);
		longint p, dstep, cd, sd, ch, sh, dx, dy, ix, iy, dl;
		logic [31:0] dang, half;
		p = longint'(w) * longint'({1'b0, dt});
		dl = round_shift(p * 2670177, 24);
		dang = dl[31:0];
		dstep = round_shift(longint'(v) * longint'({1'b0, dt}), 8);
		sincos(dang, cd, sd);
		dx = round_shift(dstep * cd, 30);
		dy = round_shift(dstep * sd, 30);
		sincos(ph, ch, sh);
		ix = round_shift(dx * ch - dy * sh, 38);
		iy = round_shift(dx * sh + dy * ch, 38);
		px = sat_sum(px, ix);
		py = sat_sum(py, iy);
		ph = ph + dang;
		half = {ph[31], ph[31:1]};
		sincos(half, ch, sh);
		q_x.push_back(px);
		q_y.push_back(py);
		q_h.push_back(ph);
		q_qz.push_back(to_q15(sh));
		q_qw.push_back(to_q15(ch));
	endfunction

	function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
				$signed(exp_v), $signed(act_v));
			errors++;
		end
	endfunction

	// Check one result transaction against the oldest prediction.
	function void check_pose(logic [31:0] x, logic [31:0] y, logic [31:0] h,
			logic [15:0] qz, logic [15:0] qw);
		if (q_x.size() == 0) begin
			$display("%0t ns: unexpected result, expected none, actual x=%0d", $time,
				$signed(x));
			errors++;
			return;
		end
		compare_field("pos_x", q_x.pop_front(), x);
		compare_field("pos_y", q_y.pop_front(), y);
		compare_field("heading", q_h.pop_front(), h);
		compare_field("quat_z", {{16{q_qz[0][15]}}, q_qz[0]}, {{16{qz[15]}}, qz});
		compare_field("quat_w", {{16{q_qw[0][15]}}, q_qw[0]}, {{16{qw[15]}}, qw});
		void'(q_qz.pop_front());
		void'(q_qw.pop_front());
	endfunction

	function int pending();
		return q_x.size();
	endfunction
endclass

module tb_odometry_pose_integrator;
	import opi_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [23:0] lin_vel = 0;
	logic signed [23:0] ang_vel = 0;
	logic [15:0] elapsed = 0;
	logic out_valid;
	logic out_stall = 1;
	logic signed [31:0] pos_x, pos_y, heading;
	logic signed [15:0] quat_z, quat_w;
	logic stim_done = 0;
	pose_scoreboard pose_sb;

	odometry_pose_integrator uut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Send one motion transaction after a random gap; valid stays high after
	// acceptance only when the next transaction follows with no gap.
	task automatic send_motion(logic signed [23:0] v, logic signed [23:0] w,
			logic [15:0] dt);
		int gap;
		gap = $urandom_range(0, 13);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		lin_vel <= v;
		ang_vel <= w;
		elapsed <= dt;
		do @(posedge clk); while (in_stall);
		pose_sb.note_motion(v, w, dt);
	endtask

	task automatic wait_drained();
		while (pose_sb.pending() != 0) @(posedge clk);
	endtask

	// Random speed, biased toward the extremes now and then.
	function automatic logic signed [23:0] pick_speed();
		case ($urandom_range(0, 5))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return $signed(24'($urandom_range(0, 1023)) - 24'd512);
			default: return $signed(24'($urandom));
		endcase
	endfunction

	// Result side: random stall before each transaction, checked on acceptance.
	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				out_stall <= 1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!out_valid);
			pose_sb.check_pose(pos_x, pos_y, heading, quat_z, quat_w);
		end
	end

	// Stimulus.
	initial begin
		pose_sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Directed: extremes, zero time, large turns and quaternion sign.
		send_motion(0, 0, 0);
		send_motion(24'sh7FFFFF, 0, 16'hFFFF);
		send_motion(24'sh800000, 0, 16'hFFFF);
		send_motion(24'sh010000, 24'sh7FFFFF, 16'hFFFF);
		send_motion(24'sh010000, 24'sh800000, 16'hFFFF);
		send_motion(24'sh7FFFFF, 24'sh7FFFFF, 0);
		send_motion(24'sh010000, 24'sh03243F, 16'h8000);
		send_motion(24'sh010000, 24'sh03243F, 16'h8000);
		send_motion(24'sh7FFFFF, 24'sh000100, 16'hFFFF);
		send_motion(24'sh800000, 24'sh000100, 16'hFFFF);
		send_motion(24'sh555555, 24'shAAAAAA, 16'h5555);
		send_motion(24'shAAAAAA, 24'sh555555, 16'hAAAA);
		// Drive x far out to reach saturation.
		for (int i = 0; i < 12; i++) send_motion(24'sh7FFFFF, 0, 16'hFFFF);
		in_valid <= 0;
		wait_drained();
		for (int i = 0; i < 1500; i++) begin
			if (i == 700) begin
				in_valid <= 0;
				wait_drained();
			end
			send_motion(pick_speed(), pick_speed(),
				($urandom_range(0, 9) == 0) ? 16'h0 : 16'($urandom));
		end
		in_valid <= 0;
		stim_done = 1;
	end

	// Finish once every prediction has been matched.
	initial begin
		wait (stim_done);
		wait_drained();
		repeat (200) @(posedge clk);
		if (pose_sb.errors == 0 && pose_sb.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule

### odometry_pose_integrator.f
sv/opi_pkg.sv
sv/odometry_pose_integrator.sv
sim/tb_odometry_pose_integrator.sv
